FILE: rtl/core/brf_pkg.sv
// Package for the bit-plane rectangle fill unit.
// Holds request and result structs, command, status and register codes.
// No dependencies.
`default_nettype none

package brf_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_END_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PX  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_PX = 3'd7;

	localparam logic CMD_FILL = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [1:0] ST_FILLED  = 2'd0;
	localparam logic [1:0] ST_SKIPPED = 2'd1;
	localparam logic [1:0] ST_READ    = 2'd2;

	// shift-add multiplier: one scale bit per cycle
	localparam int MUL_STEPS = 32;
	localparam int MUL_CNT_W = 5;

	// a 6-bit plane over words of at least 8 bits spans at most 8 words
	localparam int PLANE_WORDS_MAX = 8;
	localparam int PLANE_WORD_W    = 3;

	typedef struct packed {
		logic              command;
		logic signed [31:0] corner_ax;
		logic signed [31:0] corner_ay;
		logic signed [31:0] corner_bx;
		logic signed [31:0] corner_by;
		logic [5:0]        plane;
		logic [15:0]       read_pixel;
		logic              read_word;
	} brf_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_data;
	} brf_out_t;

	typedef struct packed {
		logic rd_en;
		logic rmw;
	} brf_mem_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/brf_mul.sv
// Shared shift-add multiplier of the fill unit, 32 x 32 to 64 bits.
// One multiplier bit per cycle; depends on brf_pkg.
`default_nettype none

module brf_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] mcand,
	input  wire logic [31:0] mplier,
	output logic             done,
	output logic [63:0]      prod
);
	import brf_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [63:0]          mcand_q;
	logic [31:0]          mplier_q;
	logic [63:0]          acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !run_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !run_q) begin
			acc_q    <= '0;
			mcand_q  <= {32'd0, mcand};
			mplier_q <= mplier;
		end else if (run_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[62:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[31:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

FILE: rtl/core/brf_store.sv
// Pixel word store of the fill unit with read-modify-write and clearing pass.
// One read and one write per cycle once the clearing pass is done; depends on brf_pkg.
`default_nettype none

module brf_store #(
	parameter int WORD_BITS = 32,
	parameter int DEPTH     = 131072,
	parameter int AW        = 17
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire brf_pkg::brf_mem_ctl_t    ctl,
	input  wire logic [AW-1:0]            addr,
	input  wire logic [WORD_BITS-1:0]     mask,
	output logic [WORD_BITS-1:0]          rd_data,
	output logic                          clear_done
);
	import brf_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_q;
	logic [AW-1:0]        clr_q;
	logic                 clr_done_q;
	logic                 pend_s1;
	logic [AW-1:0]        addr_s1;
	logic [WORD_BITS-1:0] mask_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
			pend_s1    <= 1'b0;
		end else begin
			pend_s1 <= ctl.rd_en && ctl.rmw;
			if (!clr_done_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1))
					clr_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_done_q)
			mem[clr_q] <= '0;
		else if (pend_s1)
			mem[addr_s1] <= rd_q | mask_s1;
		if (ctl.rd_en)
			rd_q <= mem[addr];
		addr_s1 <= addr;
		mask_s1 <= mask;
	end

	assign rd_data    = rd_q;
	assign clear_done = clr_done_q;

endmodule

`default_nettype wire

FILE: rtl/core/bitplane_rectangle_fill_unit.sv
// Top level of the bit-plane rectangle fill unit: sequencer, clip and scale.
// Uses brf_pkg, brf_mul and brf_store.
//
// channel   dir  payload              handshake
// in        in   brf_in_t request     in_valid / in_stall
// out       out  brf_out_t result     out_valid / out_stall
// cfg       in   32-bit register      cfg_we, cfg_index, cfg_data
//
// A read goes through S_RDW to S_RES. A fill orders and clips the corners, then
// scales each corner coordinate that lands past the window origin in the shared
// shift-add multiplier, then fills the rectangle one pixel word at a time (one store
// port pair) and ends with S_DRAIN and S_RES. A plane beyond the stored words goes
// straight to S_RES, and a point box stops after S_CHECK. After reset all
// WORDS*MAX_WIDTH*MAX_HEIGHT store words are cleared, with in_stall high; a waiting
// result in the output register does not block the next request.
`default_nettype none

module bitplane_rectangle_fill_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int WORD_BITS  = 32,
	parameter int WORDS      = 2
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire brf_pkg::brf_in_t                  in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output brf_pkg::brf_out_t                      out_data,
	input  wire logic                              cfg_we,
	input  wire logic [brf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [brf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import brf_pkg::*;

	localparam int PLANE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int DEPTH      = WORDS * PLANE_SIZE;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW         = (PLANE_SIZE > 1) ? $clog2(PLANE_SIZE) : 1;
	localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CW         = (XW > YW) ? XW : YW;
	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int HW         = $clog2(MAX_HEIGHT + 1);
	localparam int SZW0       = (WW > HW) ? WW : HW;
	localparam int SZW        = (SZW0 > 9) ? SZW0 : 9;
	localparam int RMW        = CW + WW;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ORDER = 4'd1;
	localparam logic [3:0] S_CLIP  = 4'd2;
	localparam logic [3:0] S_CHECK = 4'd3;
	localparam logic [3:0] S_DIFF  = 4'd4;
	localparam logic [3:0] S_MUL   = 4'd5;
	localparam logic [3:0] S_FSET  = 4'd6;
	localparam logic [3:0] S_FILL  = 4'd7;
	localparam logic [3:0] S_DRAIN = 4'd8;
	localparam logic [3:0] S_RDW   = 4'd9;
	localparam logic [3:0] S_RES   = 4'd10;

	logic signed [31:0] origin_x_q, origin_y_q, end_x_q, end_y_q;
	logic [31:0]        scale_x_q, scale_y_q;
	logic [8:0]         width_q, height_q;

	logic [3:0]         state_q;
	logic [1:0]         k_q;
	logic signed [32:0] coord_q [4];
	logic [CW-1:0]      pix_q [4];
	logic [WORD_BITS-1:0] mask_q;
	logic [AW-1:0]      base_q;
	logic               rd_ok_q;
	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q;
	logic [PW-1:0]      row_q;
	brf_out_t           res_q;
	logic               out_valid_q;
	brf_out_t           out_q;

	logic                    accept;
	logic                    clear_done;
	logic [PLANE_WORD_W-1:0] word_c;
	logic [5:0]              bit_c;
	logic                    plane_ok_c;
	logic [WORD_BITS-1:0]    mask_c;
	logic [AW-1:0]           base_c;
	logic                    rd_ok_c;
	logic [AW-1:0]           rd_addr_c;
	logic [AW-1:0]           fill_addr_c;
	logic signed [32:0]      coord_c, lo_c, hi_c, hi_m1_c, clip_c;
	logic signed [33:0]      diff_c;
	logic                    pos_c;
	logic [SZW-1:0]          wext_c, hext_c;
	logic [WW-1:0]           w_c;
	logic [HW-1:0]           h_c;
	logic [CW-1:0]           lim_m1_c;
	logic [47:0]             q_c;
	logic [CW-1:0]           pix_sat_c;
	logic [RMW-1:0]          row0_c;
	logic                    last_c;
	logic                    out_free;
	logic                    mul_start;
	logic                    mul_done;
	logic [63:0]             mul_prod;
	logic [31:0]             mul_b;
	brf_mem_ctl_t            mem_ctl;
	logic [AW-1:0]           mem_addr;
	logic [WORD_BITS-1:0]    rd_data;

	assign in_stall = (state_q != S_IDLE) || !clear_done;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		word_c = '0;
		for (int i = 1; i < PLANE_WORDS_MAX; i++) begin
			if (int'(in_data.plane) >= i * WORD_BITS)
				word_c = PLANE_WORD_W'(i);
		end
		bit_c      = 6'(int'(in_data.plane) - int'(word_c) * WORD_BITS);
		plane_ok_c = int'(word_c) < WORDS;
		mask_c     = WORD_BITS'(1) << bit_c;
		base_c     = AW'(int'(word_c) * PLANE_SIZE);
		rd_ok_c    = (int'(in_data.read_word) < WORDS)
			&& (int'(in_data.read_pixel) < PLANE_SIZE);
		rd_addr_c  = AW'(int'(in_data.read_word) * PLANE_SIZE + int'(in_data.read_pixel));
	end

	always_comb begin
		wext_c = SZW'(width_q);
		hext_c = SZW'(height_q);
		if (wext_c == '0)
			w_c = WW'(1);
		else if (wext_c > SZW'(MAX_WIDTH))
			w_c = WW'(MAX_WIDTH);
		else
			w_c = WW'(wext_c);
		if (hext_c == '0)
			h_c = HW'(1);
		else if (hext_c > SZW'(MAX_HEIGHT))
			h_c = HW'(MAX_HEIGHT);
		else
			h_c = HW'(hext_c);
	end

	always_comb begin
		coord_c = coord_q[k_q];
		lo_c    = k_q[1] ? 33'(origin_y_q) : 33'(origin_x_q);
		hi_c    = k_q[1] ? 33'(end_y_q) : 33'(end_x_q);
		hi_m1_c = hi_c - 33'sd1;
		priority if (coord_c < lo_c)
			clip_c = lo_c;
		else if (coord_c >= hi_c)
			clip_c = hi_m1_c;
		else
			clip_c = coord_c;
		diff_c    = 34'(coord_c) - 34'(lo_c);
		pos_c     = !diff_c[33] && (diff_c != '0);
		mul_b     = k_q[1] ? scale_y_q : scale_x_q;
		lim_m1_c  = k_q[1] ? CW'(h_c - HW'(1)) : CW'(w_c - WW'(1));
		q_c       = mul_prod[63:16];
		pix_sat_c = (q_c > 48'(lim_m1_c)) ? lim_m1_c : CW'(q_c);
	end

	assign mul_start   = (state_q == S_DIFF) && pos_c;
	assign row0_c      = RMW'(pix_q[2]) * RMW'(w_c);
	assign fill_addr_c = base_q + AW'(row_q) + AW'(x_q);
	assign last_c      = (x_q == XW'(pix_q[1])) && (y_q == YW'(pix_q[3]));

	always_comb begin
		mem_ctl.rd_en = 1'b0;
		mem_ctl.rmw   = 1'b0;
		mem_addr      = rd_addr_c;
		if (state_q == S_FILL) begin
			mem_ctl.rd_en = 1'b1;
			mem_ctl.rmw   = 1'b1;
			mem_addr      = fill_addr_c;
		end else if (accept && in_data.command == CMD_READ && rd_ok_c) begin
			mem_ctl.rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			end_x_q    <= 32'sd256;
			end_y_q    <= 32'sd256;
			scale_x_q  <= 32'd65536;
			scale_y_q  <= 32'd65536;
			width_q    <= 9'd256;
			height_q   <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:  origin_x_q <= cfg_data;
				CFG_ORIGIN_Y:  origin_y_q <= cfg_data;
				CFG_END_X:     end_x_q    <= cfg_data;
				CFG_END_Y:     end_y_q    <= cfg_data;
				CFG_SCALE_X:   scale_x_q  <= cfg_data;
				CFG_SCALE_Y:   scale_y_q  <= cfg_data;
				CFG_WIDTH_PX:  width_q    <= cfg_data[8:0];
				CFG_HEIGHT_PX: height_q   <= cfg_data[8:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						k_q <= '0;
						if (in_data.command == CMD_READ)
							state_q <= S_RDW;
						else if (!plane_ok_c)
							state_q <= S_RES;
						else
							state_q <= S_ORDER;
					end
				end
				S_ORDER: state_q <= S_CLIP;
				S_CLIP: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (coord_q[0] == coord_q[1] && coord_q[2] == coord_q[3])
						state_q <= S_RES;
					else
						state_q <= S_DIFF;
				end
				S_DIFF: begin
					if (pos_c)
						state_q <= S_MUL;
					else begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3)
							state_q <= S_FSET;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						k_q <= k_q + 2'd1;
						state_q <= (k_q == 2'd3) ? S_FSET : S_DIFF;
					end
				end
				S_FSET: state_q <= S_FILL;
				S_FILL: begin
					if (last_c)
						state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_RES;
				S_RDW:   state_q <= S_RES;
				S_RES: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					coord_q[0] <= 33'(in_data.corner_ax);
					coord_q[1] <= 33'(in_data.corner_bx);
					coord_q[2] <= 33'(in_data.corner_ay);
					coord_q[3] <= 33'(in_data.corner_by);
					mask_q     <= mask_c;
					base_q     <= base_c;
					rd_ok_q    <= rd_ok_c;
					res_q      <= '{status: ST_SKIPPED, read_data: '0};
				end
			end
			S_ORDER: begin
				if (coord_q[0] > coord_q[1]) begin
					coord_q[0] <= coord_q[1];
					coord_q[1] <= coord_q[0];
				end
				if (coord_q[2] > coord_q[3]) begin
					coord_q[2] <= coord_q[3];
					coord_q[3] <= coord_q[2];
				end
			end
			S_CLIP:  coord_q[k_q] <= clip_c;
			S_CHECK: ;
			S_DIFF: begin
				if (!pos_c)
					pix_q[k_q] <= '0;
			end
			S_MUL: begin
				if (mul_done)
					pix_q[k_q] <= pix_sat_c;
			end
			S_FSET: begin
				x_q   <= XW'(pix_q[0]);
				y_q   <= YW'(pix_q[2]);
				row_q <= PW'(row0_c);
			end
			S_FILL: begin
				if (x_q == XW'(pix_q[1])) begin
					x_q   <= XW'(pix_q[0]);
					y_q   <= y_q + YW'(1);
					row_q <= row_q + PW'(w_c);
				end else begin
					x_q <= x_q + XW'(1);
				end
			end
			S_DRAIN: res_q <= '{status: ST_FILLED, read_data: '0};
			S_RDW:   res_q <= '{status: ST_READ, read_data: rd_ok_q ? 32'(rd_data) : 32'd0};
			S_RES:   ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_RES && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RES && out_free)
			out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	brf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (diff_c[31:0]),
		.mplier (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	brf_store #(
		.WORD_BITS (WORD_BITS),
		.DEPTH     (DEPTH),
		.AW        (AW)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mem_ctl),
		.addr       (mem_addr),
		.mask       (mask_q),
		.rd_data    (rd_data),
		.clear_done (clear_done)
	);

endmodule

`default_nettype wire

FILE: rtl/core/brf_checker.sv
// Port-level checks for the bit-plane rectangle fill unit, bound to the top.
// Depends on brf_pkg and bitplane_rectangle_fill_unit.
`default_nettype none

module brf_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire brf_pkg::brf_out_t out_data
);
	import brf_pkg::*;

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while previous one still in progress");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	a_fill_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_READ |-> out_data.read_data == 32'd0)
		else $error("fill result carries non-zero read data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result dropped or changed");

endmodule

bind bitplane_rectangle_fill_unit brf_checker u_brf_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for bitplane_rectangle_fill_unit: directed and random fill and
// read requests over several window, scale and raster settings, checked against a
// behavioural raster model held here. Depends on brf_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
	import brf_pkg::*;

	localparam int RASTER_MAX_W = 256;
	localparam int RASTER_MAX_H = 256;
	localparam int PLANE_BITS   = 32;
	localparam int PIXEL_WORDS  = 2;
	localparam int PLANE_PIXELS = RASTER_MAX_W * RASTER_MAX_H;
	localparam int HOLD_CYCLES  = 3000;
	localparam int QUIET_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 64;
	localparam int REPORT_LIMIT = 10;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	brf_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	brf_out_t              out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	longint      win_left, win_bottom, win_right, win_top;
	bit [31:0]   scale_h, scale_v;
	bit [8:0]    raster_w_reg, raster_h_reg;
	bit [31:0]   raster_words [PIXEL_WORDS*PLANE_PIXELS];
	brf_out_t    owed_results [$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          idle_on = 1'b1;
	bit          hold_request = 1'b0;
	bit          medium_boxes = 1'b0;
	int unsigned last_paint_pix = 0;
	int unsigned last_paint_span = 1;
	bit          last_paint_word = 1'b0;

	bitplane_rectangle_fill_unit #(
		.MAX_WIDTH(RASTER_MAX_W),
		.MAX_HEIGHT(RASTER_MAX_H),
		.WORD_BITS(PLANE_BITS),
		.WORDS(PIXEL_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint clip_to_window(longint p, longint lo, longint hi);
		if (p < lo)
			return lo;
		if (p >= hi)
			return hi - 1;
		return p;
	endfunction

	function automatic int unsigned to_raster(longint offs, bit [31:0] scale, int unsigned lim);
		bit [63:0] span_bits;
		bit [63:0] prod;
		if (offs <= 0)
			return 0;
		span_bits = offs;
		prod = (span_bits * {32'd0, scale}) >> 16;
		if (prod > 64'(lim - 1))
			return lim - 1;
		return prod[31:0];
	endfunction

	function automatic int unsigned raster_extent(bit [8:0] v, int unsigned max_px);
		if (v == 0)
			return 1;
		if (v > max_px)
			return max_px;
		return 32'(v);
	endfunction

	// paint or read the raster copy; returns the result the unit owes
	function automatic brf_out_t apply_command(brf_in_t req);
		brf_out_t    res;
		longint      ax, ay, bx, by, t;
		int unsigned word, w, h, cx0, cx1, cy0, cy1;
		bit [31:0]   mask;
		res = '0;
		if (req.command == CMD_READ) begin
			res.status = ST_READ;
			if (req.read_word < PIXEL_WORDS && req.read_pixel < PLANE_PIXELS)
				res.read_data = raster_words[req.read_word * PLANE_PIXELS + req.read_pixel];
			return res;
		end
		word = req.plane / PLANE_BITS;
		mask = 32'd1 << (req.plane % PLANE_BITS);
		if (word >= PIXEL_WORDS) begin
			res.status = ST_SKIPPED;
			return res;
		end
		ax = $signed(req.corner_ax);
		ay = $signed(req.corner_ay);
		bx = $signed(req.corner_bx);
		by = $signed(req.corner_by);
		if (ax > bx) begin
			t = ax;
			ax = bx;
			bx = t;
		end
		if (ay > by) begin
			t = ay;
			ay = by;
			by = t;
		end
		ax = clip_to_window(ax, win_left, win_right);
		bx = clip_to_window(bx, win_left, win_right);
		ay = clip_to_window(ay, win_bottom, win_top);
		by = clip_to_window(by, win_bottom, win_top);
		if (ax == bx && ay == by) begin
			res.status = ST_SKIPPED;
			return res;
		end
		w = raster_extent(raster_w_reg, RASTER_MAX_W);
		h = raster_extent(raster_h_reg, RASTER_MAX_H);
		cx0 = to_raster(ax - win_left, scale_h, w);
		cx1 = to_raster(bx - win_left, scale_h, w);
		cy0 = to_raster(ay - win_bottom, scale_v, h);
		cy1 = to_raster(by - win_bottom, scale_v, h);
		for (int unsigned y = cy0; y <= cy1; y++)
			for (int unsigned x = cx0; x <= cx1; x++)
				raster_words[word * PLANE_PIXELS + y * w + x] |= mask;
		last_paint_word = word[0];
		last_paint_pix = cy0 * w + cx0;
		last_paint_span = (cy1 - cy0) * w + (cx1 - cx0) + 1;
		res.status = ST_FILLED;
		return res;
	endfunction

	function automatic longint near_window(longint lo, longint hi);
		longint offs;
		offs = longint'($urandom_range(0, 8)) - 4;
		case ($urandom_range(0, 3))
			0: return lo + offs;
			1: return hi + offs;
			default: begin
				if (hi <= lo)
					return lo + offs;
				return lo + (longint'($urandom) % (hi - lo + 1));
			end
		endcase
	endfunction

	function automatic brf_in_t random_request();
		brf_in_t req;
		longint  ax, ay, bx, by;
		int      reach;
		req = '0;
		req.command = ($urandom_range(0, 9) < 3) ? CMD_READ : CMD_FILL;
		req.corner_ax = $urandom;
		req.corner_ay = $urandom;
		req.corner_bx = $urandom;
		req.corner_by = $urandom;
		req.plane = 6'($urandom_range(0, 63));
		req.read_pixel = 16'($urandom);
		req.read_word = 1'($urandom);
		if (req.command == CMD_READ) begin
			// aim most reads at the last painted rectangle
			if ($urandom_range(0, 4) < 3) begin
				req.read_pixel = 16'(last_paint_pix + $urandom_range(0, last_paint_span - 1));
				req.read_word = last_paint_word;
			end
			return req;
		end
		reach = (medium_boxes && $urandom_range(0, 6) == 0) ? 40 : 6;
		ax = near_window(win_left, win_right);
		ay = near_window(win_bottom, win_top);
		bx = ax + longint'($urandom_range(0, 2 * reach)) - reach;
		by = ay + longint'($urandom_range(0, 2 * reach)) - reach;
		req.corner_ax = ax[31:0];
		req.corner_ay = ay[31:0];
		req.corner_bx = bx[31:0];
		req.corner_by = by[31:0];
		case ($urandom_range(0, 49))
			0: begin
				req.corner_ax = $urandom;
				req.corner_bx = $urandom;
			end
			1: begin
				req.corner_ay = $urandom;
				req.corner_by = $urandom;
			end
			default: ;
		endcase
		return req;
	endfunction

	task automatic send_request(input brf_in_t req);
		if (idle_on && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		owed_results.push_back(apply_command(req));
	endtask

	task automatic fill_box(input longint ax, ay, bx, by, input logic [5:0] plane);
		brf_in_t req;
		req = '0;
		req.command = CMD_FILL;
		req.corner_ax = ax[31:0];
		req.corner_ay = ay[31:0];
		req.corner_bx = bx[31:0];
		req.corner_by = by[31:0];
		req.plane = plane;
		req.read_pixel = 16'($urandom);
		req.read_word = 1'($urandom);
		send_request(req);
	endtask

	task automatic read_word_at(input logic [15:0] pix, input logic wsel);
		brf_in_t req;
		req = '0;
		req.command = CMD_READ;
		req.corner_ax = $urandom;
		req.corner_ay = $urandom;
		req.corner_bx = $urandom;
		req.corner_by = $urandom;
		req.plane = 6'($urandom_range(0, 63));
		req.read_pixel = pix;
		req.read_word = wsel;
		send_request(req);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ORIGIN_X:  win_left = longint'($signed(value));
			CFG_ORIGIN_Y:  win_bottom = longint'($signed(value));
			CFG_END_X:     win_right = longint'($signed(value));
			CFG_END_Y:     win_top = longint'($signed(value));
			CFG_SCALE_X:   scale_h = value;
			CFG_SCALE_Y:   scale_v = value;
			CFG_WIDTH_PX:  raster_w_reg = value[8:0];
			CFG_HEIGHT_PX: raster_h_reg = value[8:0];
			default: ;
		endcase
	endtask

	task automatic set_window(input longint ox, oy, ex, ey, input bit [31:0] sx, sy,
			input bit [8:0] w, h);
		drain_results();
		write_register(CFG_ORIGIN_X, ox[31:0]);
		write_register(CFG_ORIGIN_Y, oy[31:0]);
		write_register(CFG_END_X, ex[31:0]);
		write_register(CFG_END_Y, ey[31:0]);
		write_register(CFG_SCALE_X, sx);
		write_register(CFG_SCALE_Y, sy);
		write_register(CFG_WIDTH_PX, {23'd0, w});
		write_register(CFG_HEIGHT_PX, {23'd0, h});
	endtask

	task automatic run_random(input int count, input bit allow_idle);
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				idle_on = allow_idle && $urandom_range(0, 3) != 0;
			send_request(random_request());
		end
		drain_results();
	endtask

	task automatic test_directed();
		idle_on = 1'b1;
		read_word_at(16'd0, 1'b0);
		read_word_at(16'hFFFF, 1'b1);
		fill_box(10, 10, 10, 10, 6'd5);
		fill_box(-5, -1, -100, -64'sd2147483648, 6'd7);
		fill_box(300, 256, 2147483647, 1000, 6'd9);
		fill_box(20, 7, 10, 3, 6'd0);
		read_word_at(16'(5 * 256 + 15), 1'b0);
		// whole raster, corners at the field extremes
		fill_box(-64'sd2147483648, 2147483647, 2147483647, -64'sd2147483648, 6'd63);
		read_word_at(16'hFFFF, 1'b1);
		fill_box(100, 0, 100, 255, 6'd32);
		fill_box(0, 200, 255, 200, 6'd31);
		read_word_at(16'(200 * 256 + 100), 1'b0);
		read_word_at(16'(200 * 256 + 100), 1'b1);
		fill_box(255, 255, 254, 255, 6'd17);
		fill_box(50, 50, 51, 50, 6'd1);
		read_word_at(16'(50 * 256 + 51), 1'b0);
		read_word_at(16'(255 * 256 + 254), 1'b0);
		read_word_at(16'h5A5A, 1'b1);
		drain_results();
	endtask

	task automatic test_random_default();
		medium_boxes = 1'b1;
		run_random(700, 1'b1);
		medium_boxes = 1'b0;
	endtask

	task automatic test_offset_window();
		set_window(-1000, 500, -700, 540, 32'h0000_C000, 32'h0002_0000, 9'd200, 9'd80);
		run_random(350, 1'b1);
	endtask

	task automatic test_extreme_window();
		set_window(-64'sd2147483648, -64'sd2147483648, 2147483647, 2147483647,
			32'hFFFF_FFFF, 32'h0000_0000, 9'd0, 9'h1FF);
		run_random(250, 1'b1);
	endtask

	task automatic test_inverted_window();
		set_window(100, 32'h7FFF_FFF5, 50, 32'h7FFF_FFFF,
			32'h0000_0001, 32'h0003_0000, 9'd17, 9'd9);
		run_random(250, 1'b1);
	endtask

	task automatic test_result_backpressure();
		idle_on = 1'b0;
		@(posedge clk);
		hold_request = 1'b1;
		for (int i = 0; i < 60; i++)
			send_request(random_request());
		drain_results();
	endtask

	task automatic test_unbroken_stream();
		set_window(-5, -5, 59, 59, 32'h0004_0000, 32'h0000_8000, 9'd256, 9'd37);
		idle_on = 1'b0;
		run_random(300, 1'b0);
	endtask

	// result side: random stall bursts while idle_on is set, or a long hold when asked
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 4);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		brf_out_t want;
		if (out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: status %0d data %h",
						out_data.status, out_data.read_data);
			end else begin
				want = owed_results.pop_front();
				if (out_data.status !== want.status || out_data.read_data !== want.read_data) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result mismatch: status exp %0d got %0d, data exp %h got %h",
							want.status, out_data.status, want.read_data, out_data.read_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		win_left = 0;
		win_bottom = 0;
		win_right = 256;
		win_top = 256;
		scale_h = 32'h0001_0000;
		scale_v = 32'h0001_0000;
		raster_w_reg = 9'd256;
		raster_h_reg = 9'd256;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_default();
		test_offset_window();
		test_extreme_window();
		test_inverted_window();
		test_result_backpressure();
		test_unbroken_stream();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/brf_pkg.sv
rtl/core/brf_mul.sv
rtl/core/brf_store.sv
rtl/core/bitplane_rectangle_fill_unit.sv
rtl/core/brf_checker.sv
dv/testbench.sv
